>>> design/annexb_ns_pkg.sv
package annexb_ns_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // scanner phases
  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_EPB    = 8'h03;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;
  localparam logic [1:0] HELD_MAX     = 2'd3;

  // everything one input byte produces, in output order:
  // header, zeros, data byte, unit end
  typedef struct packed {
    logic       hdr;
    logic [1:0] ref_idc;
    logic [4:0] unit_type;
    logic [2:0] zeros;
    logic       byte_en;
    logic [7:0] data;
    logic       end_en;
  } nal_bundle_t;

  function automatic logic bundle_busy(input nal_bundle_t b);
    return b.hdr || (b.zeros != 3'd0) || b.byte_en || b.end_en;
  endfunction

endpackage

>>> design/annexb_nal_splitter.sv
// channel | direction | handshake                | beat contents
// --------+-----------+--------------------------+---------------------------------
// in      | in        | in_valid_i / in_ready_o  | stream_byte_i, stream_end_i
// out     | out       | out_valid_o / out_ready_i| kind_o, payload_o, ref_idc_o,
//         |           |                          | unit_type_o, run_last_o
//
// one input beat per cycle unless full; 0 to 5 out beats each, one per cycle
// an input beat is scanned in the cycle it is taken and lands in a two-deep
// result queue; out beats come from the queue head in the following cycles
// in_ready_o drops only while both queue slots hold results (held-zero bursts)
// rst_ni clears the scanner to "searching" and empties the queue
// a stalled output holds its beat; input keeps flowing until the queue fills
module annexb_nal_splitter
  import annexb_ns_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_o,
  output logic [1:0] ref_idc_o,
  output logic [4:0] unit_type_o,
  output logic       run_last_o
);

  nal_bundle_t bundle;
  logic        full;
  logic        take;
  logic        push;

  // accept whenever the second queue slot is free
  assign in_ready_o = !full;
  assign take       = in_valid_i && in_ready_o;
  // bytes that produce nothing (searching, held zeros) skip the queue
  assign push       = take && bundle_busy(bundle);

  // start-code scan, zero holding and emulation-prevention removal
  annexb_ns_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .stream_byte_i (stream_byte_i),
    .stream_end_i  (stream_end_i),
    .bundle_o      (bundle)
  );

  // result queue and per-beat serializer
  annexb_ns_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bundle_i    (bundle),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .payload_o   (payload_o),
    .ref_idc_o   (ref_idc_o),
    .unit_type_o (unit_type_o),
    .run_last_o  (run_last_o)
  );

endmodule

>>> design/annexb_ns_parser.sv
module annexb_ns_parser
  import annexb_ns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        stream_end_i,
  output nal_bundle_t bundle_o
);

  logic [1:0] phase_q, phase_d;
  logic [1:0] held_q, held_d;
  logic [1:0] run_q, run_d;
  logic       closed;

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    run_d    = run_q;
    closed   = 1'b0;
    bundle_o = '0;
    case (phase_q)
      PH_HEADER: begin
        bundle_o.hdr       = 1'b1;
        bundle_o.ref_idc   = stream_byte_i[6:5];
        bundle_o.unit_type = stream_byte_i[4:0];
        phase_d = PH_PAYLOAD;
        held_d  = 2'd0;
        run_d   = 2'd0;
      end
      PH_PAYLOAD: begin
        if (stream_byte_i == BYTE_ZERO) begin
          // a fourth held zero pushes the oldest one out
          if (held_q == HELD_MAX) bundle_o.zeros = 3'd1;
          else                    held_d = held_q + 2'd1;
          if (run_q < ZERO_RUN_MAX) run_d = run_q + 2'd1;
        end else if (stream_byte_i == BYTE_ONE && held_q >= 2'd2) begin
          bundle_o.end_en = 1'b1;
          closed  = 1'b1;
          held_d  = 2'd0;
          run_d   = 2'd0;
          phase_d = PH_HEADER;
        end else begin
          bundle_o.zeros   = {1'b0, held_q};
          held_d           = 2'd0;
          bundle_o.byte_en = !(stream_byte_i == BYTE_EPB && run_q >= ZERO_RUN_MAX);
          bundle_o.data    = stream_byte_i;
          run_d            = 2'd0;
        end
      end
      default: begin
        phase_d = PH_SEARCH;
        if (stream_byte_i == BYTE_ZERO) begin
          if (held_q < 2'd2) held_d = held_q + 2'd1;
        end else if (stream_byte_i == BYTE_ONE && held_q >= 2'd2) begin
          held_d  = 2'd0;
          run_d   = 2'd0;
          phase_d = PH_HEADER;
        end else begin
          held_d = 2'd0;
        end
      end
    endcase

    if (stream_end_i) begin
      // flush held zeros and close an open unit
      if (phase_d == PH_PAYLOAD && !closed) begin
        bundle_o.zeros  = bundle_o.zeros + {1'b0, held_d};
        bundle_o.end_en = 1'b1;
      end
      phase_d = PH_SEARCH;
      held_d  = 2'd0;
      run_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      held_q  <= 2'd0;
      run_q   <= 2'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      run_q   <= run_d;
    end
  end

endmodule

>>> design/annexb_ns_emitter.sv
module annexb_ns_emitter
  import annexb_ns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  nal_bundle_t bundle_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_o,
  output logic [1:0]  ref_idc_o,
  output logic [4:0]  unit_type_o,
  output logic        run_last_o
);

  nal_bundle_t slot0_q, slot1_q, rest;
  logic        v0_q, v1_q;
  logic        take, pop;

  // pick the next result off the head bundle
  always_comb begin
    rest        = slot0_q;
    kind_o      = KIND_END;
    payload_o   = 8'h00;
    ref_idc_o   = 2'd0;
    unit_type_o = 5'd0;
    if (slot0_q.hdr) begin
      kind_o      = KIND_HEADER;
      ref_idc_o   = slot0_q.ref_idc;
      unit_type_o = slot0_q.unit_type;
      rest.hdr    = 1'b0;
    end else if (slot0_q.zeros != 3'd0) begin
      kind_o     = KIND_PAYLOAD;
      rest.zeros = slot0_q.zeros - 3'd1;
    end else if (slot0_q.byte_en) begin
      kind_o       = KIND_PAYLOAD;
      payload_o    = slot0_q.data;
      rest.byte_en = 1'b0;
    end else begin
      rest.end_en = 1'b0;
    end
  end

  assign run_last_o  = !bundle_busy(rest);
  assign out_valid_o = v0_q;
  assign full_o      = v1_q;
  assign take        = v0_q && out_ready_i;
  assign pop         = take && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (pop) begin
        v0_q <= v1_q || push_i;
        v1_q <= v1_q && push_i;
      end else if (push_i) begin
        v0_q <= 1'b1;
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (v1_q) begin
        slot0_q <= slot1_q;
        if (push_i) slot1_q <= bundle_i;
      end else if (push_i) begin
        slot0_q <= bundle_i;
      end
    end else begin
      if (take) slot0_q <= rest;
      if (push_i) begin
        if (v0_q) slot1_q <= bundle_i;
        else      slot0_q <= bundle_i;
      end
    end
  end

  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q) else $error("second slot filled with empty head");

  a_head_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> bundle_busy(slot0_q)) else $error("head bundle holds no result");

  a_zero_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !run_last_o && !slot0_q.hdr && slot0_q.zeros != 3'd0)
      |=> slot0_q.zeros == $past(slot0_q.zeros) - 3'd1)
    else $error("held zero count not decremented");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && v1_q) |-> pop) else $error("push into full queue");

endmodule
